// ===== rtl/aarm_pkg.sv =====
// Shared types, constants and helper functions of the axis-angle rotation matrix core.
package aarm_pkg;

  // Fixed-point setup
  localparam int FRAC_BITS     = 14;  // fraction bits of c, s and the matrix entries
  localparam int CORDIC_STAGES = 16;  // CORDIC iterations, one pipeline stage each
  localparam int ATAN_LEN      = 24;
  localparam int WORK_FRAC     = 30;
  localparam int AXIS_FRAC     = 14;
  localparam int RND_SH        = 2 * AXIS_FRAC;

  localparam int ANGLE_W = 16;
  localparam int AXIS_W  = 16;
  localparam int ROT_W   = 18;
  localparam int ROT_N   = 9;
  localparam int AA_N    = 6;

  localparam int IN_TDATA_W  = ANGLE_W + 3 * AXIS_W;
  localparam int OUT_TDATA_W = ((ROT_N * ROT_W + 7) / 8) * 8;

  localparam int XY_W  = 33;
  localparam int Z_W   = 33;
  localparam int CS_SH = WORK_FRAC - FRAC_BITS;
  localparam int CS_W  = FRAC_BITS + 3;
  localparam int L_W   = CS_W + 1;
  localparam int AA_W  = 2 * AXIS_W;
  localparam int LA_W  = L_W + AA_W;
  localparam int AS_W  = AXIS_W + CS_W;
  localparam int TERM_W = FRAC_BITS + 38;
  localparam int RES_W  = TERM_W - RND_SH;

  typedef logic signed [XY_W-1:0]   xy_t;
  typedef logic signed [Z_W-1:0]    z_t;
  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [CS_W-1:0]   cs_t;
  typedef logic signed [ROT_W-1:0]  rot_t;

  localparam xy_t CORDIC_X0 = 33'sd652032874;
  localparam xy_t CS_HALF   = {{(XY_W-1){1'b0}}, 1'b1} << (CS_SH - 1);
  localparam logic signed [L_W-1:0] ONE_L = {{(L_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [TERM_W-1:0] TERM_HALF =
    {{(TERM_W-1){1'b0}}, 1'b1} << (RND_SH - 1);
  localparam logic signed [RES_W-1:0] ROT_MAX = RES_W'(131071);
  localparam logic signed [RES_W-1:0] ROT_MIN = -RES_W'(131072);

  // atan(2^-i) in turns, 2^32 = one turn
  localparam z_t ATAN_TURNS [ATAN_LEN] = '{
    33'sh20000000, 33'sh12E4051E, 33'sh09FB385B, 33'sh051111D4, 33'sh028B0D43,
    33'sh0145D7E1, 33'sh00A2F61E, 33'sh00517C55, 33'sh0028BE53, 33'sh00145F2F,
    33'sh000A2F98, 33'sh000517CC, 33'sh00028BE6, 33'sh000145F3, 33'sh0000A2FA,
    33'sh0000517D, 33'sh000028BE, 33'sh0000145F, 33'sh00000A30, 33'sh00000518,
    33'sh0000028C, 33'sh00000146, 33'sh000000A3, 33'sh00000051
  };

  typedef struct packed {
    xy_t        x;
    xy_t        y;
    z_t         z;
    logic [1:0] quad;
    axis_t      ax;
    axis_t      ay;
    axis_t      az;
  } cordic_t;

  // One rotation-mode micro-rotation; shifts floor toward minus infinity
  function automatic cordic_t cordic_step(input cordic_t v, input int sh, input z_t at);
    cordic_t r;
    xy_t     dx;
    xy_t     dy;
    r  = v;
    dx = v.y >>> sh;
    dy = v.x >>> sh;
    if (!v.z[Z_W-1]) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - at;
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + at;
    end
    return r;
  endfunction

  // Slot of a_i*a_j among the six distinct axis products
  function automatic int aa_slot(input int i, input int j);
    if (i == j) return i;
    if (i + j == 1) return 3;
    if (i + j == 2) return 4;
    return 5;
  endfunction

  function automatic rot_t sat_rot(input logic signed [RES_W-1:0] r);
    if (r > ROT_MAX) return rot_t'(ROT_MAX);
    if (r < ROT_MIN) return rot_t'(ROT_MIN);
    return r[ROT_W-1:0];
  endfunction

endpackage

// ===== rtl/axis_angle_rotation_matrix_core.sv =====
// Top level of the axis-angle (Rodrigues) rotation matrix core.
//
//  channel  direction  tdata fields (lowest bit first)
//  s_axis   in         angle[15:0], axis_x[31:16], axis_y[47:32], axis_z[63:48]
//  m_axis   out        rot_00 .. rot_22, 18 bits each row-major, bits 167:162 zero
//
// Throughput: one word per cycle unless back-pressure from m_tready has filled the pipe.
// Path: one CORDIC micro-rotation per stage, then three back-end stages
// (round, multiply, sum/round/saturate).
// Reset clears every valid bit; data registers are not reset.
// Stalls: each stage holds only while it is full and the stage after it holds,
// so bubbles collapse and input keeps flowing while a result waits, until every stage is full.
module axis_angle_rotation_matrix_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // angle, axis_x, axis_y, axis_z
  input  logic [aarm_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22, zero pad
  output logic [aarm_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  localparam int AW = aarm_pkg::ANGLE_W;
  localparam int XW = aarm_pkg::AXIS_W;

  // CORDIC to back end
  logic              cord_valid;
  logic              cord_ready;
  aarm_pkg::cordic_t cord_data;

  aarm_pkg::rot_t rot [aarm_pkg::ROT_N];

  // Sine/cosine of the angle; the axis rides along unchanged
  aarm_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .angle     (s_tdata[AW-1:0]),
    .axis_x    (s_tdata[AW+XW-1:AW]),
    .axis_y    (s_tdata[AW+2*XW-1:AW+XW]),
    .axis_z    (s_tdata[AW+3*XW-1:AW+2*XW]),
    .out_valid (cord_valid),
    .out_ready (cord_ready),
    .out_data  (cord_data)
  );

  // Matrix entries; its last stage is the output register
  aarm_matrix u_matrix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cord_valid),
    .in_ready  (cord_ready),
    .in_data   (cord_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .rot       (rot)
  );

  // Pack row-major, rot_00 in the lowest bits, pad with zeros
  always_comb begin
    m_tdata = '0;
    for (int e = 0; e < aarm_pkg::ROT_N; e++) begin
      m_tdata[e*aarm_pkg::ROT_W +: aarm_pkg::ROT_W] = rot[e];
    end
  end

  // Reset leaves the output empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word present right after reset");

  // With the output free, every stage can advance, so input is taken
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while the output is free");

  // A CORDIC word is held only while the output holds a word that is not taken
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (cord_valid && !cord_ready) |-> m_tvalid && !m_tready)
    else $error("CORDIC stage stalled while the output drains");

  // The residual angle has converged after the last micro-rotation
  a_cordic_conv: assert property (@(posedge clk) disable iff (rst)
    cord_valid |->
      (cord_data.z < (aarm_pkg::ATAN_TURNS[aarm_pkg::CORDIC_STAGES-1] <<< 1)) &&
      (cord_data.z > -(aarm_pkg::ATAN_TURNS[aarm_pkg::CORDIC_STAGES-1] <<< 1)))
    else $error("CORDIC residual angle did not converge");

endmodule

// ===== rtl/aarm_cordic.sv =====
// CORDIC sine/cosine pipeline with quadrant reduction; carries the axis alongside.
module aarm_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aarm_pkg::ANGLE_W-1:0]  angle,
  input  aarm_pkg::axis_t               axis_x,
  input  aarm_pkg::axis_t               axis_y,
  input  aarm_pkg::axis_t               axis_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output aarm_pkg::cordic_t             out_data
);

  localparam int N = aarm_pkg::CORDIC_STAGES;

  aarm_pkg::cordic_t st [N];
  logic [N-1:0]      vld;
  logic [N:0]        en;
  aarm_pkg::cordic_t seed;

  logic [aarm_pkg::ANGLE_W:0] asum;
  logic [13:0]                res;

  // Nearest quadrant and residual in [-8192, 8191]
  always_comb begin
    asum      = {1'b0, angle} + 17'd8192;
    res       = {~asum[13], asum[12:0]};
    seed.x    = aarm_pkg::CORDIC_X0;
    seed.y    = '0;
    seed.z    = {{(aarm_pkg::Z_W-30){res[13]}}, res, 16'b0};
    seed.quad = asum[15:14];
    seed.ax   = axis_x;
    seed.ay   = axis_y;
    seed.az   = axis_z;
  end

  assign en[N] = out_ready;

  for (genvar i = 0; i < N; i++) begin : g_stage
    aarm_pkg::cordic_t prev;
    logic              prev_vld;

    if (i == 0) begin : g_first
      assign prev     = seed;
      assign prev_vld = in_valid;
    end else begin : g_next
      assign prev     = st[i-1];
      assign prev_vld = vld[i-1];
    end

    // Load when empty or when the next stage takes the current word
    assign en[i] = !vld[i] || en[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en[i]) begin
        vld[i] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        st[i] <= aarm_pkg::cordic_step(prev, i, aarm_pkg::ATAN_TURNS[i]);
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[N-1];
  assign out_data  = st[N-1];

endmodule

// ===== rtl/aarm_matrix.sv =====
// Rodrigues back end: quadrant map and rounding, products, sums with round and saturate.
module aarm_matrix (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aarm_pkg::cordic_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aarm_pkg::rot_t    rot [aarm_pkg::ROT_N]
);

  // Stage A: c, s, l and axis products
  logic                                 va;
  aarm_pkg::cs_t                        ca;
  aarm_pkg::cs_t                        sa;
  logic signed [aarm_pkg::L_W-1:0]      la;
  logic signed [aarm_pkg::AA_W-1:0]     aaa [aarm_pkg::AA_N];
  aarm_pkg::axis_t                      axa [3];
  // Stage B: l*a_i*a_j and a_k*s
  logic                                 vb;
  aarm_pkg::cs_t                        cb;
  logic signed [aarm_pkg::LA_W-1:0]     lab [aarm_pkg::AA_N];
  logic signed [aarm_pkg::AS_W-1:0]     asb [3];
  // Stage C: finished entries
  logic                                 vc;

  logic en_a, en_b, en_c;

  aarm_pkg::xy_t cq, sq, cr, sr;
  aarm_pkg::cs_t c_next, s_next;
  aarm_pkg::axis_t ax_in [3];

  assign en_c     = !vc || out_ready;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  assign ax_in[0] = in_data.ax;
  assign ax_in[1] = in_data.ay;
  assign ax_in[2] = in_data.az;

  always_comb begin
    case (in_data.quad)
      2'd0: begin
        cq = in_data.x;
        sq = in_data.y;
      end
      2'd1: begin
        cq = -in_data.y;
        sq = in_data.x;
      end
      2'd2: begin
        cq = -in_data.x;
        sq = -in_data.y;
      end
      default: begin
        cq = in_data.y;
        sq = -in_data.x;
      end
    endcase
    cr     = (cq + aarm_pkg::CS_HALF) >>> aarm_pkg::CS_SH;
    sr     = (sq + aarm_pkg::CS_HALF) >>> aarm_pkg::CS_SH;
    c_next = cr[aarm_pkg::CS_W-1:0];
    s_next = sr[aarm_pkg::CS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      ca <= c_next;
      sa <= s_next;
      la <= aarm_pkg::ONE_L - aarm_pkg::L_W'(c_next);
    end
    if (en_b) begin
      cb <= ca;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_axis
    always_ff @(posedge clk) begin
      if (en_a) axa[k] <= ax_in[k];
      if (en_b) asb[k] <= axa[k] * sa;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = i; j < 3; j++) begin : g_col
      localparam int P = aarm_pkg::aa_slot(i, j);
      always_ff @(posedge clk) begin
        if (en_a) aaa[P] <= ax_in[i] * ax_in[j];
        if (en_b) lab[P] <= la * aaa[P];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ent_r
    for (genvar j = 0; j < 3; j++) begin : g_ent_c
      localparam int P = aarm_pkg::aa_slot(i, j);
      // Axis index of the sine term; the diagonal has none
      localparam int K = (i == j) ? i : 3 - i - j;
      logic signed [aarm_pkg::TERM_W-1:0] t;
      logic signed [aarm_pkg::TERM_W-1:0] tr;

      always_comb begin
        if (i == j) begin
          t = aarm_pkg::TERM_W'(lab[P])
            + (aarm_pkg::TERM_W'(cb) <<< aarm_pkg::RND_SH);
        end else if (j == (i + 1) % 3) begin
          t = aarm_pkg::TERM_W'(lab[P])
            - (aarm_pkg::TERM_W'(asb[K]) <<< aarm_pkg::AXIS_FRAC);
        end else begin
          t = aarm_pkg::TERM_W'(lab[P])
            + (aarm_pkg::TERM_W'(asb[K]) <<< aarm_pkg::AXIS_FRAC);
        end
        tr = (t + aarm_pkg::TERM_HALF) >>> aarm_pkg::RND_SH;
      end

      always_ff @(posedge clk) begin
        if (en_c) begin
          rot[i*3+j] <= aarm_pkg::sat_rot(tr[aarm_pkg::RES_W-1:0]);
        end
      end
    end
  end

  assign out_valid = vc;

endmodule

// ===== tb/sv/axis_angle_rotation_matrix_core_tb.sv =====
// Self-checking testbench for the axis-angle rotation matrix core.
module axis_angle_rotation_matrix_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROT_BITS   = aarm_pkg::ROT_N * aarm_pkg::ROT_W;
  localparam int LATENCY    = aarm_pkg::CORDIC_STAGES + 3;
  localparam int RANDOM_N   = 2000;
  localparam int CYCLE_CAP  = 400000;
  localparam int PARK_AFTER = 600;   // matrices seen before the long output hold-off
  localparam int PARK_LEN   = 400;   // cycles of that hold-off
  localparam int QUIET_TAIL = 300;   // last words of the run go without idling

  // CORDIC seed: gain 0.60725293500888 in Q30
  localparam longint CORDIC_GAIN = 64'd652032874;
  localparam longint ROT_HI = 131071;
  localparam longint ROT_LO = -131072;

  // atan(2^-i) as a fraction of a turn, 2^32 = one turn
  localparam longint ATAN_STEP [24] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
    'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
    'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
  };

  typedef struct packed {
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
    logic        [15:0] angle;
  } rot_req_t;

  // Nine matrix entries, rot_00 in the lowest slot, same layout as m_tdata
  typedef logic [aarm_pkg::ROT_N-1:0][aarm_pkg::ROT_W-1:0] mat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  // angle, axis_x, axis_y, axis_z
  logic [aarm_pkg::IN_TDATA_W-1:0]    s_tdata = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22, zero pad
  logic [aarm_pkg::OUT_TDATA_W-1:0]   m_tdata;

  rot_req_t pending_rotations [$];  // words still to offer
  mat_t     expected_mats [$];      // predicted matrices, oldest first

  rot_req_t cur_req;
  int       n_items    = 0;
  int       sent_cnt   = 0;
  int       mats_seen  = 0;
  int       errors     = 0;
  int       gap_left   = 0;
  int       stall_left = 0;
  int       park_left  = 0;
  logic     parked     = 1'b0;
  logic     park_done  = 1'b0;
  logic     next_ready;
  mat_t     got_mat;
  mat_t     want_mat;

  axis_angle_rotation_matrix_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Rodrigues matrix of one request: CORDIC cos/sin of the residual angle, fold back
  // the quadrant, round c and s, then build each entry exactly, round it once and saturate it.
  function automatic mat_t rodrigues_matrix(input rot_req_t req);
    longint ang, quo, resid, x, y, z, dx, dy, cv, sv, lv, t;
    longint a [3];
    longint a_sin [3];
    int     quad, i, j, k, sh;
    mat_t   m;
    ang   = req.angle;
    quo   = (ang + 8192) >>> 14;
    resid = ang - quo * 16384;
    quad  = int'(quo & 3);
    x = CORDIC_GAIN;
    y = 0;
    z = resid * 65536;
    a[0] = req.ax;
    a[1] = req.ay;
    a[2] = req.az;
    for (i = 0; i < aarm_pkg::CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[i];
      end
    end
    case (quad)
      0: begin cv = x;  sv = y;  end
      1: begin cv = -y; sv = x;  end
      2: begin cv = -x; sv = -y; end
      default: begin cv = y; sv = -x; end
    endcase
    sh = 30 - aarm_pkg::FRAC_BITS;
    cv = (cv + (longint'(1) << (sh - 1))) >>> sh;
    sv = (sv + (longint'(1) << (sh - 1))) >>> sh;
    lv = (longint'(1) << aarm_pkg::FRAC_BITS) - cv;
    for (k = 0; k < 3; k++) a_sin[k] = a[k] * sv * 16384;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        t = lv * (a[i] * a[j]);
        if (i == j) begin
          t = t + cv * (longint'(1) << 28);
        end else begin
          k = 3 - i - j;
          // cyclic successor pairs subtract the sine term, the others add it
          if (j == (i + 1) % 3) t = t - a_sin[k];
          else t = t + a_sin[k];
        end
        t = (t + (longint'(1) << 27)) >>> 28;
        if (t > ROT_HI) t = ROT_HI;
        if (t < ROT_LO) t = ROT_LO;
        m[i * 3 + j] = t[aarm_pkg::ROT_W-1:0];
      end
    end
    return m;
  endfunction

  task automatic add_rotation(input int angle, input int ax, input int ay, input int az);
    rot_req_t r;
    r.angle = angle[15:0];
    r.ax    = ax[15:0];
    r.ay    = ay[15:0];
    r.az    = az[15:0];
    pending_rotations.push_back(r);
  endtask

  // Random direction scaled to unit length in Q1.14
  task automatic unit_axis(output int ax, output int ay, output int az);
    int  ux, uy, uz;
    real norm;
    norm = 0.0;
    while (norm == 0.0) begin
      ux = int'($urandom_range(0, 40000)) - 20000;
      uy = int'($urandom_range(0, 40000)) - 20000;
      uz = int'($urandom_range(0, 40000)) - 20000;
      norm = $sqrt(real'(ux) * ux + real'(uy) * uy + real'(uz) * uz);
    end
    ax = $rtoi(real'(ux) * 16384.0 / norm);
    ay = $rtoi(real'(uy) * 16384.0 / norm);
    az = $rtoi(real'(uz) * 16384.0 / norm);
  endtask

  // Driver: offer the next pending word whenever the current one is taken or none is up.
  // Predict a matrix at the edge that accepts a word.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_mats.push_back(rodrigues_matrix(cur_req));
        sent_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          // idle burst on the input side
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_rotations.size() > 0) begin
          cur_req = pending_rotations.pop_front();
          s_tdata  <= {cur_req.az, cur_req.ay, cur_req.ax, cur_req.angle};
          s_tvalid <= 1'b1;
          // arm a gap after this word, except in calm stretches, the tail and the hold-off
          if ((sent_cnt % 500) < 350 && sent_cnt + QUIET_TAIL < n_items && !parked &&
              $urandom_range(0, 4) == 0)
            gap_left = $urandom_range(1, 9);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest prediction and pace m_tready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_mat = m_tdata[ROT_BITS-1:0];
        if (expected_mats.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected matrix word %0d: %h", mats_seen, m_tdata);
        end else begin
          want_mat = expected_mats.pop_front();
          for (int f = 0; f < aarm_pkg::ROT_N; f++) begin
            if (got_mat[f] !== want_mat[f]) begin
              errors++;
              if (errors <= 10)
                $display("matrix word %0d rot_%0d%0d: expected %0d, got %0d", mats_seen,
                         f / 3, f % 3, $signed(want_mat[f]), $signed(got_mat[f]));
            end
          end
          if (m_tdata[aarm_pkg::OUT_TDATA_W-1:ROT_BITS] !== '0) begin
            errors++;
            if (errors <= 10)
              $display("matrix word %0d: pad bits not zero: %h", mats_seen,
                       m_tdata[aarm_pkg::OUT_TDATA_W-1:ROT_BITS]);
          end
        end
        mats_seen++;
      end
      // ready for the next edge: hold-off, then stall bursts, else take
      if (parked) begin
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if ((mats_seen % 500) < 350 && mats_seen + QUIET_TAIL < n_items &&
            $urandom_range(0, 4) == 0)
          stall_left = $urandom_range(1, 9);
      end
      m_tready <= next_ready;
    end
  end

  // Long output hold-off, once: the sender keeps offering so the pipe fills and
  // back-pressure must reach s_tready.
  always @(posedge clk) begin
    if (rst) begin
      parked    <= 1'b0;
      park_done <= 1'b0;
      park_left <= 0;
    end else if (parked) begin
      if (park_left == 1) parked <= 1'b0;
      park_left <= park_left - 1;
    end else if (!park_done && mats_seen >= PARK_AFTER) begin
      parked    <= 1'b1;
      park_done <= 1'b1;
      park_left <= PARK_LEN;
    end
  end

  // Watchdog: end a hung run
  initial begin
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int angle, ax, ay, az, kind;

    // Directed: axes along each direction, quadrant edges, wrap of the top quadrant,
    // angle extremes, zero axis, unnormalized and out-of-range axes that saturate.
    add_rotation(0,     16384,  0,      0);
    add_rotation(16384, 16384,  0,      0);
    add_rotation(32768, 0,      16384,  0);
    add_rotation(49152, 0,      0,      16384);
    add_rotation(65535, 0,      0,      16384);
    add_rotation(8191,  9459,   9459,   9459);
    add_rotation(8192,  9459,   9459,   9459);
    add_rotation(24575, 0,      -16384, 0);
    add_rotation(24576, -16384, 0,      0);
    add_rotation(57343, 0,      0,      -16384);
    add_rotation(57344, 11585,  11585,  0);
    add_rotation(61440, 0,      11585,  -11585);
    add_rotation(32768, -32768, -32768, -32768);
    add_rotation(16384, 32767,  32767,  32767);
    add_rotation(49152, -32768, 32767,  -32768);
    add_rotation(0,     0,      0,      0);
    add_rotation(32768, 0,      0,      0);
    add_rotation(65535, -16384, -16384, -16384);
    add_rotation(40000, 16384,  16384,  16384);
    add_rotation(4096,  -1,     1,      -1);
    add_rotation(12345, -32768, 0,      32767);

    // Random: unit axes half the time, else raw in-range axes or full 16-bit axes
    for (int n = 0; n < RANDOM_N; n++) begin
      if ($urandom_range(0, 7) == 0)
        angle = int'($urandom_range(0, 3)) * 16384 + 8192 + int'($urandom_range(0, 3)) - 2;
      else
        angle = $urandom_range(0, 65535);
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        unit_axis(ax, ay, az);
      end else if (kind < 8) begin
        ax = int'($urandom_range(0, 32768)) - 16384;
        ay = int'($urandom_range(0, 32768)) - 16384;
        az = int'($urandom_range(0, 32768)) - 16384;
      end else begin
        ax = int'($urandom_range(0, 65535)) - 32768;
        ay = int'($urandom_range(0, 65535)) - 32768;
        az = int'($urandom_range(0, 65535)) - 32768;
      end
      add_rotation(angle, ax, ay, az);
    end
    n_items = pending_rotations.size();

    // hold reset, then release
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // drain: every word sent, every prediction checked, then watch for strays
    while (sent_cnt < n_items) @(posedge clk);
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
